// ----- hw/rtl/ttst_pkg.sv -----
// Shared types, character codes and microcode table of the template-to-script translator.
package ttst_pkg;

  localparam int PcW = 7;
  typedef logic [PcW-1:0] pc_t;
  typedef logic [7:0]     byte_t;

  localparam byte_t CH_QUOTE = 8'h22;
  localparam byte_t CH_CR    = 8'h0D;
  localparam byte_t CH_LF    = 8'h0A;
  localparam byte_t CH_LT    = 8'h3C;
  localparam byte_t CH_GT    = 8'h3E;
  localparam byte_t CH_PCT   = 8'h25;

  typedef enum logic {
    SRC_LIT,
    SRC_DATA
  } src_t;

  typedef enum logic [2:0] {
    C_NONE,
    C_ALWAYS,
    C_OPEN,
    C_CR,
    C_LF,
    C_QT,
    C_END,
    C_LT
  } cond_t;

  typedef struct packed {
    logic  emit;
    src_t  src;
    byte_t lit;
    cond_t cond;
    pc_t   target;
    logic  fin;
  } uword_t;

  typedef struct packed {
    logic  valid;
    logic  emit;
    logic  fin;
    byte_t data;
  } step_t;

  localparam pc_t A_END      = 7'd0;
  localparam pc_t A_PCT      = 7'd1;
  localparam pc_t A_PCTD     = 7'd2;
  localparam pc_t A_DAT      = 7'd3;
  localparam pc_t A_CRLF2    = 7'd4;
  localparam pc_t A_ENDCHK   = 7'd6;
  localparam pc_t A_CLS      = 7'd8;
  localparam pc_t A_TB       = 7'd11;
  localparam pc_t A_TB_CH    = 7'd24;
  localparam pc_t A_QDUP     = 7'd26;
  localparam pc_t A_TB_CR    = 7'd27;
  localparam pc_t A_TB_OPEN  = 7'd29;
  localparam pc_t A_CLS_CRLF = 7'd32;
  localparam pc_t A_LT       = 7'd51;
  localparam pc_t A_LT_CH    = 7'd62;

  function automatic uword_t mk(input logic e, input src_t s, input byte_t b,
                                input cond_t c, input pc_t t, input logic f);
    uword_t w;
    w.emit   = e;
    w.src    = s;
    w.lit    = b;
    w.cond   = c;
    w.target = t;
    w.fin    = f;
    return w;
  endfunction

  function automatic uword_t u_lit(input byte_t b, input logic f);
    return mk(1'b1, SRC_LIT, b, C_NONE, A_END, f);
  endfunction

  function automatic uword_t u_jump(input cond_t c, input pc_t t);
    return mk(1'b0, SRC_LIT, 8'h00, c, t, 1'b0);
  endfunction

  function automatic uword_t u_end();
    return mk(1'b0, SRC_LIT, 8'h00, C_NONE, A_END, 1'b1);
  endfunction

  function automatic uword_t urom(input pc_t a);
    uword_t w;
    unique case (a)
      7'd0:  w = u_end();
      7'd1:  w = u_lit(CH_PCT, 1'b1);
      7'd2:  w = u_lit(CH_PCT, 1'b0);
      7'd3:  w = mk(1'b1, SRC_DATA, 8'h00, C_NONE, A_END, 1'b1);
      7'd4:  w = u_lit(CH_CR, 1'b0);
      7'd5:  w = u_lit(CH_LF, 1'b1);
      7'd6:  w = u_jump(C_OPEN, A_CLS);
      7'd7:  w = u_end();
      7'd8:  w = u_lit(CH_QUOTE, 1'b0);
      7'd9:  w = u_lit(CH_CR, 1'b0);
      7'd10: w = u_lit(CH_LF, 1'b1);
      7'd11: w = u_jump(C_CR, A_TB_CR);
      7'd12: w = u_jump(C_LF, A_END);
      7'd13: w = u_jump(C_OPEN, A_TB_CH);
      7'd14: w = u_lit("s", 1'b0);
      7'd15: w = u_lit("o", 1'b0);
      7'd16: w = u_lit(".", 1'b0);
      7'd17: w = u_lit("w", 1'b0);
      7'd18: w = u_lit("r", 1'b0);
      7'd19: w = u_lit("i", 1'b0);
      7'd20: w = u_lit("t", 1'b0);
      7'd21: w = u_lit("e", 1'b0);
      7'd22: w = u_lit(" ", 1'b0);
      7'd23: w = u_lit(CH_QUOTE, 1'b0);
      7'd24: w = mk(1'b1, SRC_DATA, 8'h00, C_QT, A_QDUP, 1'b0);
      7'd25: w = u_end();
      7'd26: w = mk(1'b1, SRC_DATA, 8'h00, C_NONE, A_END, 1'b1);
      7'd27: w = u_jump(C_OPEN, A_CLS_CRLF);
      7'd28: w = u_end();
      7'd29: w = u_jump(C_CR, A_CLS_CRLF);
      7'd30: w = u_jump(C_LF, A_END);
      7'd31: w = u_jump(C_ALWAYS, A_TB_CH);
      7'd32: w = u_lit(CH_QUOTE, 1'b0);
      7'd33: w = u_lit(CH_CR, 1'b0);
      7'd34: w = u_lit(CH_LF, 1'b0);
      7'd35: w = u_lit("s", 1'b0);
      7'd36: w = u_lit("o", 1'b0);
      7'd37: w = u_lit(".", 1'b0);
      7'd38: w = u_lit("w", 1'b0);
      7'd39: w = u_lit("r", 1'b0);
      7'd40: w = u_lit("i", 1'b0);
      7'd41: w = u_lit("t", 1'b0);
      7'd42: w = u_lit("e", 1'b0);
      7'd43: w = u_lit(" ", 1'b0);
      7'd44: w = u_lit("v", 1'b0);
      7'd45: w = u_lit("b", 1'b0);
      7'd46: w = u_lit("C", 1'b0);
      7'd47: w = u_lit("r", 1'b0);
      7'd48: w = u_lit("L", 1'b0);
      7'd49: w = u_lit("f", 1'b0);
      7'd50: w = u_lit(CH_LF, 1'b1);
      7'd51: w = u_jump(C_OPEN, A_LT_CH);
      7'd52: w = u_lit("s", 1'b0);
      7'd53: w = u_lit("o", 1'b0);
      7'd54: w = u_lit(".", 1'b0);
      7'd55: w = u_lit("w", 1'b0);
      7'd56: w = u_lit("r", 1'b0);
      7'd57: w = u_lit("i", 1'b0);
      7'd58: w = u_lit("t", 1'b0);
      7'd59: w = u_lit("e", 1'b0);
      7'd60: w = u_lit(" ", 1'b0);
      7'd61: w = u_lit(CH_QUOTE, 1'b0);
      7'd62: w = mk(1'b1, SRC_LIT, CH_LT, C_END, A_CLS, 1'b0);
      7'd63: w = u_jump(C_LT, A_END);
      7'd64: w = u_jump(C_ALWAYS, A_TB_OPEN);
      default: w = u_end();
    endcase
    return w;
  endfunction

endpackage

// ----- hw/rtl/ttst_ifs.sv -----
// Valid/ready channel interfaces for template input and script output.
interface ttst_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_flag;

  modport source (output valid, output data_byte, output end_flag, input ready);
  modport sink (input valid, input data_byte, input end_flag, output ready);
endinterface

interface ttst_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

// ----- hw/rtl/template_to_script_translator_core.sv -----
// Top level of the template-to-script translator: sequencer plus output stage.
// Throughput: one microcode step per cycle, at most one script byte per cycle, unless the
// output stage stalls the sequencer; the sequencer takes no new item until the final step
// of its current item's program is taken.
// Reset: rst_n (synchronous) returns to text mode, no line open, no lead byte held.
module template_to_script_translator_core
  import ttst_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  ttst_in_if.sink    in_ch,
  ttst_out_if.source out_ch
);

  step_t step;
  logic  ack;

  ttst_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .step  (step),
    .ack   (ack)
  );

  ttst_emit u_emit (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .ack    (ack),
    .out_ch (out_ch)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("sequencer did not start after a transaction");

  a_fin_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step.valid && step.fin && ack |=> in_ch.ready)
    else $error("sequencer stayed busy after its final step");

  a_idle_no_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !step.valid)
    else $error("microcode step issued while idle");

endmodule

// ----- hw/rtl/ttst_ctrl.sv -----
// Translator state, entry dispatch and microcode sequencer.
module ttst_ctrl
  import ttst_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  ttst_in_if.sink   in_ch,
  output step_t     step,
  input  logic      ack
);

  logic  mode_r, open_r, lead_r;
  logic  busy_r;
  pc_t   pc_r;
  byte_t data_r;
  logic  end_r;
  logic  open0_r;

  pc_t   entry;
  logic  mode_nxt, open_nxt, lead_nxt;
  logic  in_lt, in_pct, in_gt, in_cr, in_lf;
  logic  taken;
  logic  accept;
  uword_t w;

  assign in_ch.ready = !busy_r;
  assign accept      = in_ch.valid && !busy_r;

  assign in_lt  = (in_ch.data_byte == CH_LT);
  assign in_pct = (in_ch.data_byte == CH_PCT);
  assign in_gt  = (in_ch.data_byte == CH_GT);
  assign in_cr  = (in_ch.data_byte == CH_CR);
  assign in_lf  = (in_ch.data_byte == CH_LF);

  always_comb begin
    entry    = A_END;
    mode_nxt = mode_r;
    open_nxt = open_r;
    lead_nxt = lead_r;
    priority if (in_ch.end_flag) begin
      entry    = lead_r ? (mode_r ? A_PCT : A_LT) : A_ENDCHK;
      mode_nxt = 1'b0;
      open_nxt = 1'b0;
      lead_nxt = 1'b0;
    end else if (mode_r) begin
      if (lead_r) begin
        lead_nxt = 1'b0;
        if (in_gt) begin
          entry    = A_CRLF2;
          mode_nxt = 1'b0;
        end else begin
          entry = A_PCTD;
        end
      end else if (in_pct) begin
        lead_nxt = 1'b1;
      end else begin
        entry = A_DAT;
      end
    end else if (lead_r) begin
      lead_nxt = 1'b0;
      if (in_pct) begin
        entry    = A_ENDCHK;
        open_nxt = 1'b0;
        mode_nxt = 1'b1;
      end else begin
        entry = A_LT;
        if (in_lt) begin
          lead_nxt = 1'b1;
          open_nxt = 1'b1;
        end else begin
          open_nxt = !in_cr;
        end
      end
    end else if (in_lt) begin
      lead_nxt = 1'b1;
    end else begin
      entry = A_TB;
      if (in_cr) begin
        open_nxt = 1'b0;
      end else if (!in_lf) begin
        open_nxt = 1'b1;
      end
    end
  end

  assign w = urom(pc_r);

  always_comb begin
    unique case (w.cond)
      C_NONE:   taken = 1'b0;
      C_ALWAYS: taken = 1'b1;
      C_OPEN:   taken = open0_r;
      C_CR:     taken = (data_r == CH_CR);
      C_LF:     taken = (data_r == CH_LF);
      C_QT:     taken = (data_r == CH_QUOTE);
      C_END:    taken = end_r;
      C_LT:     taken = (data_r == CH_LT);
      default:  taken = 1'b0;
    endcase
  end

  assign step.valid = busy_r;
  assign step.emit  = w.emit;
  assign step.fin   = w.fin;
  assign step.data  = (w.src == SRC_DATA) ? data_r : w.lit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      open_r <= 1'b0;
      lead_r <= 1'b0;
      busy_r <= 1'b0;
      pc_r   <= A_END;
    end else if (busy_r) begin
      if (ack) begin
        if (w.fin) begin
          busy_r <= 1'b0;
        end else begin
          pc_r <= taken ? w.target : pc_r + 7'd1;
        end
      end
    end else if (accept) begin
      mode_r  <= mode_nxt;
      open_r  <= open_nxt;
      lead_r  <= lead_nxt;
      busy_r  <= 1'b1;
      pc_r    <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data_r  <= in_ch.data_byte;
      end_r   <= in_ch.end_flag;
      open0_r <= open_r;
    end
  end

endmodule

// ----- hw/rtl/ttst_emit.sv -----
// Hold stage and output register that mark the final byte of each run.
module ttst_emit
  import ttst_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  step_t      step,
  output logic       ack,
  ttst_out_if.source out_ch
);

  logic  hold_v_r;
  byte_t hold_r;
  logic  flush_r;
  logic  out_v_r;
  byte_t out_byte_r;
  logic  out_last_r;

  logic  can_push;
  logic  push_req;
  logic  push;
  byte_t push_byte;
  logic  push_last;

  assign can_push = !out_v_r || out_ch.ready;
  assign push_req = (hold_v_r && (step.emit || step.fin)) ||
                    (!hold_v_r && step.emit && step.fin);
  assign ack      = step.valid && !flush_r && (!push_req || can_push);

  always_comb begin
    push      = 1'b0;
    push_byte = hold_r;
    push_last = 1'b0;
    if (flush_r) begin
      push      = can_push;
      push_last = 1'b1;
    end else if (ack && push_req) begin
      push = 1'b1;
      if (!hold_v_r) begin
        push_byte = step.data;
        push_last = 1'b1;
      end else begin
        push_last = step.fin && !step.emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      flush_r  <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (flush_r) begin
        if (can_push) begin
          hold_v_r <= 1'b0;
          flush_r  <= 1'b0;
        end
      end else if (ack) begin
        if (step.emit && step.fin) begin
          hold_v_r <= hold_v_r;
          flush_r  <= hold_v_r;
        end else if (step.emit) begin
          hold_v_r <= 1'b1;
        end else if (step.fin) begin
          hold_v_r <= 1'b0;
        end
      end
      if (push) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!flush_r && ack && step.emit && (hold_v_r || !step.fin)) begin
      hold_r <= step.data;
    end
    if (push) begin
      out_byte_r <= push_byte;
      out_last_r <= push_last;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.out_byte    = out_byte_r;
  assign out_ch.last_of_run = out_last_r;

endmodule
